>>> rtl/core/euler_to_quaternion_unit_defines.svh
// assertion macros shared by the checker
`ifndef EULER_TO_QUATERNION_UNIT_DEFINES_SVH
`define EULER_TO_QUATERNION_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define E2Q_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence checked in the cycle after the antecedent
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

	localparam int unsigned QF        = 30;
	localparam int unsigned FULL_TURN = 46080;
	localparam int unsigned QUARTER   = 11520;
	localparam int unsigned EIGHTH    = 5760;
	// round(pi * 2^32) split as A * 92160 + B
	localparam int unsigned PI_A      = 146408;
	localparam int unsigned PI_B      = 76425;
	localparam int unsigned PI_BIAS   = 46080;
	// floor(2^20 / 45), estimate is low by at most one
	localparam int unsigned RECIP45   = 23301;
	localparam int unsigned RECIP_SH  = 20;
	localparam int unsigned DIV45     = 45;
	localparam int unsigned N_TERMS   = 6;
	localparam int unsigned CELL_LAT  = 3;
	// reduction and folding 5, chain, sine product 1, quadrant 1
	localparam int unsigned SC_LAT    = 5 + N_TERMS * CELL_LAT + 2;

	localparam int unsigned SIN_DIV [N_TERMS] = '{156, 110, 72, 42, 20, 6};
	localparam int unsigned COS_DIV [N_TERMS] = '{132, 90, 56, 30, 12, 2};

	typedef logic [30:0] uq30_t;

	typedef struct packed {
		logic [29:0] x;
		logic        fold;
		logic [1:0]  quad;
	} aux_t;

	// unsigned q30 product, round half up
	function automatic uq30_t umul_q30(input uq30_t a, input uq30_t b);
		logic [61:0] p;
		p = 62'(a) * 62'(b) + (62'(1) << (QF - 1));
		return 31'(p >> QF);
	endfunction

	// signed q30 product, round half away from zero
	function automatic logic signed [31:0] smul_q30(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic  neg;
		uq30_t ma;
		uq30_t mb;
		uq30_t m;
		neg = a[31] ^ b[31];
		ma  = a[31] ? 31'(-a) : 31'(a);
		mb  = b[31] ? 31'(-b) : 31'(b);
		m   = umul_q30(ma, mb);
		return neg ? -32'(m) : 32'(m);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/e2q_series_cell.sv
`default_nettype none
// one nested taylor step for sine and cosine: p' = 1 - round(x2 * p / d)
module e2q_series_cell #(
	parameter int unsigned SDIV = 156,
	parameter int unsigned CDIV = 132
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [29:0]    x2,
	input  wire e2q_pkg::uq30_t ps,
	input  wire e2q_pkg::uq30_t pc,
	input  wire e2q_pkg::aux_t  aux,
	output logic [29:0]         nxt_x2,
	output e2q_pkg::uq30_t      nxt_ps,
	output e2q_pkg::uq30_t      nxt_pc,
	output e2q_pkg::aux_t       nxt_aux
);

	localparam int unsigned SK = 32 + $clog2(SDIV);
	localparam int unsigned CK = 32 + $clog2(CDIV);
	localparam logic [63:0] SR = (64'd1 << SK) / 64'(SDIV);
	localparam logic [63:0] CR = (64'd1 << CK) / 64'(CDIV);

	logic [29:0]    x2_s1, x2_s2, x2_s3;
	e2q_pkg::aux_t  aux_s1, aux_s2, aux_s3;
	e2q_pkg::uq30_t sv_s1, cv_s1;
	e2q_pkg::uq30_t svp_s2, cvp_s2, sq0_s2, cq0_s2;
	e2q_pkg::uq30_t ps_s3, pc_s3;

	logic [64:0] sm, cm;
	logic [31:0] srem, crem;
	e2q_pkg::uq30_t sq, cq;

	always_comb begin
		sm = 65'(e2q_pkg::uq30_t'(sv_s1 + 31'(SDIV / 2))) * 65'(SR);
		cm = 65'(e2q_pkg::uq30_t'(cv_s1 + 31'(CDIV / 2))) * 65'(CR);
	end

	always_comb begin
		srem = 32'(svp_s2) - 32'(sq0_s2) * 32'(SDIV);
		crem = 32'(cvp_s2) - 32'(cq0_s2) * 32'(CDIV);
		sq   = sq0_s2 + 31'(srem >= 32'(SDIV));
		cq   = cq0_s2 + 31'(crem >= 32'(CDIV));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// product with the running term
			sv_s1  <= e2q_pkg::umul_q30(31'(x2), ps);
			cv_s1  <= e2q_pkg::umul_q30(31'(x2), pc);
			x2_s1  <= x2;
			aux_s1 <= aux;
			// reciprocal estimate of the rounded quotient
			svp_s2 <= sv_s1 + 31'(SDIV / 2);
			cvp_s2 <= cv_s1 + 31'(CDIV / 2);
			sq0_s2 <= 31'(sm >> SK);
			cq0_s2 <= 31'(cm >> CK);
			x2_s2  <= x2_s1;
			aux_s2 <= aux_s1;
			// correct by one and subtract from unity
			ps_s3  <= 31'(1 << e2q_pkg::QF) - sq;
			pc_s3  <= 31'(1 << e2q_pkg::QF) - cq;
			x2_s3  <= x2_s2;
			aux_s3 <= aux_s2;
		end
	end

	assign nxt_x2  = x2_s3;
	assign nxt_ps  = ps_s3;
	assign nxt_pc  = pc_s3;
	assign nxt_aux = aux_s3;

endmodule
`default_nettype wire

>>> rtl/core/e2q_sincos.sv
`default_nettype none
// sine and cosine of a half angle in 1/128 degree units, signed q30
module e2q_sincos (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [15:0] angle,
	output logic signed [31:0]      sn,
	output logic signed [31:0]      cs
);

	localparam int unsigned NT = e2q_pkg::N_TERMS;

	logic signed [16:0] ax;
	logic [15:0]        r;
	logic [1:0]         quad;
	logic [15:0]        base;
	logic [13:0]        f;

	logic [12:0] t_s1;
	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4;
	logic        fold_s1, fold_s2, fold_s3, fold_s4;
	logic [30:0] ta_s2, ta_s3;
	logic [17:0] m_s2, m_s3;
	logic [17:0] qq_s3;
	logic [17:0] rem;
	logic [29:0] x_s4;
	logic [29:0] x2_s5;
	e2q_pkg::aux_t aux_s5;

	logic [28:0] tb;
	logic [32:0] qm;

	always_comb begin
		ax = 17'(angle);
		r  = ax[16] ? 16'(ax + 17'(e2q_pkg::FULL_TURN)) : 16'(ax);
		if (r >= 16'(3 * e2q_pkg::QUARTER)) begin
			quad = 2'd3;
			base = 16'(3 * e2q_pkg::QUARTER);
		end else if (r >= 16'(2 * e2q_pkg::QUARTER)) begin
			quad = 2'd2;
			base = 16'(2 * e2q_pkg::QUARTER);
		end else if (r >= 16'(e2q_pkg::QUARTER)) begin
			quad = 2'd1;
			base = 16'(e2q_pkg::QUARTER);
		end else begin
			quad = 2'd0;
			base = 16'd0;
		end
		f = 14'(r - base);
	end

	always_comb begin
		tb  = 29'(t_s1) * 29'(e2q_pkg::PI_B) + 29'(e2q_pkg::PI_BIAS);
		qm  = 33'(m_s2) * 33'(e2q_pkg::RECIP45);
		rem = m_s3 - 18'(qq_s3 * 18'(e2q_pkg::DIV45));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// octant fold
			t_s1    <= (f <= 14'(e2q_pkg::EIGHTH)) ? 13'(f) : 13'(14'(e2q_pkg::QUARTER) - f);
			fold_s1 <= f > 14'(e2q_pkg::EIGHTH);
			quad_s1 <= quad;
			// radians: t*A + floor((t*B + bias) / 92160)
			ta_s2   <= 31'(t_s1) * 31'(e2q_pkg::PI_A);
			m_s2    <= 18'(tb >> 11);
			fold_s2 <= fold_s1;
			quad_s2 <= quad_s1;
			qq_s3   <= 18'(qm >> e2q_pkg::RECIP_SH);
			m_s3    <= m_s2;
			ta_s3   <= ta_s2;
			fold_s3 <= fold_s2;
			quad_s3 <= quad_s2;
			x_s4    <= 30'(ta_s3 + 31'(qq_s3) + 31'(rem >= 18'(e2q_pkg::DIV45)));
			fold_s4 <= fold_s3;
			quad_s4 <= quad_s3;
			x2_s5       <= 30'(e2q_pkg::umul_q30(31'(x_s4), 31'(x_s4)));
			aux_s5.x    <= x_s4;
			aux_s5.fold <= fold_s4;
			aux_s5.quad <= quad_s4;
		end
	end

	// chain of series cells, innermost term first
	logic [29:0]    x2_w  [NT+1];
	e2q_pkg::uq30_t ps_w  [NT+1];
	e2q_pkg::uq30_t pc_w  [NT+1];
	e2q_pkg::aux_t  aux_w [NT+1];

	assign x2_w[0]  = x2_s5;
	assign ps_w[0]  = 31'(1 << e2q_pkg::QF);
	assign pc_w[0]  = 31'(1 << e2q_pkg::QF);
	assign aux_w[0] = aux_s5;

	for (genvar k = 0; k < NT; k++) begin : g_cell
		e2q_series_cell #(
			.SDIV (e2q_pkg::SIN_DIV[k]),
			.CDIV (e2q_pkg::COS_DIV[k])
		) u_cell (
			.clk     (clk),
			.en      (en),
			.x2      (x2_w[k]),
			.ps      (ps_w[k]),
			.pc      (pc_w[k]),
			.aux     (aux_w[k]),
			.nxt_x2  (x2_w[k+1]),
			.nxt_ps  (ps_w[k+1]),
			.nxt_pc  (pc_w[k+1]),
			.nxt_aux (aux_w[k+1])
		);
	end

	logic [30:0] sv_s6, cv_s6;
	logic        fold_s6;
	logic [1:0]  quad_s6;
	logic signed [31:0] s0, c0;
	logic signed [31:0] sn_s7, cs_s7;

	always_comb begin
		if (fold_s6) begin
			s0 = 32'(cv_s6);
			c0 = 32'(sv_s6);
		end else begin
			s0 = 32'(sv_s6);
			c0 = 32'(cv_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sv_s6   <= e2q_pkg::umul_q30(31'(aux_w[NT].x), ps_w[NT]);
			cv_s6   <= pc_w[NT];
			fold_s6 <= aux_w[NT].fold;
			quad_s6 <= aux_w[NT].quad;
			case (quad_s6)
				2'd0: begin
					sn_s7 <= s0;
					cs_s7 <= c0;
				end
				2'd1: begin
					sn_s7 <= c0;
					cs_s7 <= -s0;
				end
				2'd2: begin
					sn_s7 <= -s0;
					cs_s7 <= -c0;
				end
				default: begin
					sn_s7 <= -c0;
					cs_s7 <= s0;
				end
			endcase
		end
	end

	assign sn = sn_s7;
	assign cs = cs_s7;

endmodule
`default_nettype wire

>>> rtl/core/euler_to_quaternion_unit.sv
// euler angles (pitch about y, yaw about z, roll about x, signed 1/64 degree)
// to the unit quaternion q = q_yaw * q_pitch * q_roll, vector part x, y, z and
// scalar w, each signed with 1 << FRAC_BITS meaning 1.0 and saturated to +-1.0.
// any 16-bit angle is taken and wraps with the period of a full turn. the
// block is a plain pipeline: one request a cycle while no result is held
// under res_stall. the depth is set by the chain of six taylor cells per
// angle plus angle folding and the two levels of hamilton products. res_stall
// freezes the whole pipeline while a result is valid, and req_stall is high
// exactly while that result sits waiting; bubbles are not squeezed out.
`default_nettype none
module euler_to_quaternion_unit #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_stall,
	input  wire logic signed [15:0]      pitch_deg,
	input  wire logic signed [15:0]      yaw_deg,
	input  wire logic signed [15:0]      roll_deg,
	output logic                         res_valid,
	input  wire logic                    res_stall,
	output logic signed [FRAC_BITS+1:0]  quat_x,
	output logic signed [FRAC_BITS+1:0]  quat_y,
	output logic signed [FRAC_BITS+1:0]  quat_z,
	output logic signed [FRAC_BITS+1:0]  quat_w
);

	localparam int OW  = FRAC_BITS + 2;
	localparam int SH  = 30 - FRAC_BITS;
	localparam longint unsigned RND = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
	localparam longint unsigned ONE = 64'd1 << FRAC_BITS;
	// sine/cosine depth plus products, products, sums, output rounding
	localparam int LAT = e2q_pkg::SC_LAT + 4;

	// whole pipeline moves unless a result is held at the output
	logic en;
	logic [LAT-1:0] vld_q;

	assign en        = !(vld_q[LAT-1] && res_stall);
	assign req_stall = !en;
	assign res_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req_valid};
		end
	end

	// half angle sine and cosine per axis
	logic signed [31:0] sp, cp, sy, cy, sr, cr;

	e2q_sincos u_pitch (.clk(clk), .en(en), .angle(pitch_deg), .sn(sp), .cs(cp));
	e2q_sincos u_yaw   (.clk(clk), .en(en), .angle(yaw_deg),   .sn(sy), .cs(cy));
	e2q_sincos u_roll  (.clk(clk), .en(en), .angle(roll_deg),  .sn(sr), .cs(cr));

	// q30 to output format, round half away from zero, clamp to unity
	function automatic logic [OW-1:0] to_out(input logic signed [32:0] v);
		logic signed [33:0] vx;
		logic [33:0]        mag;
		logic [33:0]        m;
		logic [OW-1:0]      res;
		vx  = 34'(v);
		mag = vx[33] ? 34'(-vx) : 34'(vx);
		m   = (mag + 34'(RND)) >> SH;
		if (m > 34'(ONE)) begin
			m = 34'(ONE);
		end
		res = OW'(m);
		return vx[33] ? OW'(-res) : res;
	endfunction

	logic signed [31:0] cycp_s1, sysp_s1, cysp_s1, sycp_s1, cr_s1, sr_s1;
	logic signed [31:0] wa_s2, wb_s2, xa_s2, xb_s2, ya_s2, yb_s2, za_s2, zb_s2;
	logic signed [32:0] w_s3, x_s3, y_s3, z_s3;
	logic [OW-1:0]      qx_q, qy_q, qz_q, qw_q;

	always_ff @(posedge clk) begin
		if (en) begin
			// yaw times pitch
			cycp_s1 <= e2q_pkg::smul_q30(cy, cp);
			sysp_s1 <= e2q_pkg::smul_q30(sy, sp);
			cysp_s1 <= e2q_pkg::smul_q30(cy, sp);
			sycp_s1 <= e2q_pkg::smul_q30(sy, cp);
			cr_s1   <= cr;
			sr_s1   <= sr;
			// times roll
			wa_s2 <= e2q_pkg::smul_q30(cycp_s1, cr_s1);
			wb_s2 <= e2q_pkg::smul_q30(sysp_s1, sr_s1);
			xa_s2 <= e2q_pkg::smul_q30(cycp_s1, sr_s1);
			xb_s2 <= e2q_pkg::smul_q30(sysp_s1, cr_s1);
			ya_s2 <= e2q_pkg::smul_q30(cysp_s1, cr_s1);
			yb_s2 <= e2q_pkg::smul_q30(sycp_s1, sr_s1);
			za_s2 <= e2q_pkg::smul_q30(sycp_s1, cr_s1);
			zb_s2 <= e2q_pkg::smul_q30(cysp_s1, sr_s1);
			// exact two-term sums
			w_s3 <= 33'(wa_s2) + 33'(wb_s2);
			x_s3 <= 33'(xa_s2) - 33'(xb_s2);
			y_s3 <= 33'(ya_s2) + 33'(yb_s2);
			z_s3 <= 33'(za_s2) - 33'(zb_s2);
			// output register
			qx_q <= to_out(x_s3);
			qy_q <= to_out(y_s3);
			qz_q <= to_out(z_s3);
			qw_q <= to_out(w_s3);
		end
	end

	assign quat_x = qx_q;
	assign quat_y = qy_q;
	assign quat_z = qz_q;
	assign quat_w = qw_q;

endmodule
`default_nettype wire

>>> rtl/core/e2q_checker.sv
`default_nettype none
`include "euler_to_quaternion_unit_defines.svh"
module e2q_checker #(
	parameter int FRAC_BITS = 14
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    req_stall,
	input wire logic                    res_valid,
	input wire logic                    res_stall,
	input wire logic signed [FRAC_BITS+1:0] quat_x,
	input wire logic signed [FRAC_BITS+1:0] quat_y,
	input wire logic signed [FRAC_BITS+1:0] quat_z,
	input wire logic signed [FRAC_BITS+1:0] quat_w
);

	localparam logic signed [FRAC_BITS+1:0] ONE  = (FRAC_BITS+2)'(1 << FRAC_BITS);
	localparam logic signed [FRAC_BITS+1:0] MONE = -ONE;

	// all four result fields side by side
	logic [4*(FRAC_BITS+2)-1:0] quat_all;
	assign quat_all = {quat_x, quat_y, quat_z, quat_w};

	// request side only backs up behind a held result
	`E2Q_ASSERT_IMPL(a_stall_cause, req_stall, res_valid && res_stall, "stall without held result")

	// quat_w and quat_x never exceed unit magnitude
	`E2Q_ASSERT_IMPL(a_w_range, res_valid, quat_w <= ONE && quat_w >= MONE, "quat_w beyond unity")
	`E2Q_ASSERT_IMPL(a_x_range, res_valid, quat_x <= ONE && quat_x >= MONE, "quat_x beyond unity")

	// held result keeps its value
	`E2Q_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(quat_all), "held result changed")

endmodule

bind euler_to_quaternion_unit e2q_checker #(.FRAC_BITS(FRAC_BITS)) u_e2q_checker (.*);
`default_nettype wire
